// ----- rtl/core/gkc_pkg.sv -----
// Shared types and constants for the grayscale kernel convolution block.
// Used by the front end, window queue, arithmetic back end and top level.
`default_nettype none

package gkc_pkg;

    localparam int KSIZE     = 3;
    localparam int HIST      = KSIZE - 1;
    localparam int TAPS      = KSIZE * KSIZE;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int LW_W      = 11;
    localparam int ROW_W     = 11;
    localparam int PIX_W     = 8;
    localparam int RGB_W     = 3 * PIX_W;
    localparam int COEF_W    = 12;
    localparam int ROWC_W    = KSIZE * COEF_W;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int RSUM_W    = PROD_W + 2;
    localparam int SUM_W     = RSUM_W + 1;
    localparam int FRAC_W    = 8;
    localparam int GW_W      = 16;
    localparam int GPROD_W   = PIX_W + GW_W;
    localparam int LS_W      = HIST * PIX_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QLVL_W    = QPTR_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [GW_W-1:0] GRAY_W_R = 16'd19595;
    localparam logic [GW_W-1:0] GRAY_W_G = 16'd38469;
    localparam logic [GW_W-1:0] GRAY_W_B = 16'd7471;

    localparam logic [LW_W-1:0]  LW_MIN     = LW_W'(KSIZE);
    localparam logic [LW_W-1:0]  LW_MAX     = LW_W'(MAX_WIDTH);
    localparam logic [LW_W-1:0]  LW_RESET   = LW_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] ROW_MAX    = {ROW_W{1'b1}};
    localparam logic [COL_W-1:0] COL_FIRST  = COL_W'(HIST);
    localparam logic [ROW_W-1:0] ROW_FIRST  = ROW_W'(HIST);
    localparam logic [QLVL_W:0]  QDEPTH_CMP = (QLVL_W + 1)'(QDEPTH);
    localparam logic [PIX_W-1:0] PIX_MAX    = {PIX_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ROW0 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ROW1 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ROW2 = 2'd3;

    typedef logic [KSIZE-1:0][ROWC_W-1:0] t_coeffs;

    typedef struct packed {
        logic                        row_end;
        logic [TAPS-1:0][PIX_W-1:0]  taps;
    } t_win_item;

endpackage

`default_nettype wire

// ----- rtl/core/gkc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; read of an address written in the same cycle returns old data.
`default_nettype none

module gkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/gkc_front.sv -----
// Front end: accepts pixels, tracks column and row, converts to gray,
// keeps the line store and 3x3 window, pushes complete windows. Uses gkc_pkg, gkc_ram.
`default_nettype none

module gkc_front import gkc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [RGB_W-1:0]  s_axis_tdata,   // red, green, blue
    input  wire logic              s_axis_tuser,   // frame_start
    input  wire logic [LW_W-1:0]   i_line_width,
    input  wire logic [QLVL_W-1:0] i_q_level,
    output logic                   o_push,
    output t_win_item              o_item
);

    logic             r_s0_valid;
    logic [COL_W-1:0] r_s0_col;
    logic [RGB_W-1:0] r_s0_rgb;
    logic             r_s0_emit;
    logic             r_s0_last;
    logic [COL_W-1:0] r_col_count, n_col_count;
    logic [ROW_W-1:0] r_row_count, n_row_count;
    logic             r_fwd_hit;
    logic [LS_W-1:0]  r_fwd_data;
    logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] r_window, n_window;

    logic             accept;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [LW_W-1:0]  w_eff;
    logic             last;
    logic             emit;
    logic [LS_W-1:0]  ram_rdata;
    logic [LS_W-1:0]  hist;
    logic [LS_W-1:0]  ram_wdata;
    logic [GPROD_W-1:0] gray_sum;
    logic [PIX_W-1:0] gray;
    logic [KSIZE-1:0][PIX_W-1:0] fresh;

    assign s_axis_tready = ((QLVL_W + 1)'(i_q_level) + (QLVL_W + 1)'(r_s0_valid)) < QDEPTH_CMP;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        col_cur = s_axis_tuser ? '0 : r_col_count;
        row_cur = s_axis_tuser ? '0 : r_row_count;
        if (i_line_width < LW_MIN) begin
            w_eff = LW_MIN;
        end else if (i_line_width > LW_MAX) begin
            w_eff = LW_MAX;
        end else begin
            w_eff = i_line_width;
        end
        last = (LW_W'(col_cur) + LW_W'(1)) >= w_eff;
        emit = (col_cur >= COL_FIRST) && (row_cur >= ROW_FIRST);
        n_col_count = r_col_count;
        n_row_count = r_row_count;
        if (accept) begin
            if (last) begin
                n_col_count = '0;
                n_row_count = (row_cur < ROW_MAX) ? row_cur + ROW_W'(1) : row_cur;
            end else begin
                n_col_count = col_cur + COL_W'(1);
                n_row_count = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_s0_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_window    <= '0;
        end else begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
            r_s0_valid  <= accept;
            r_fwd_hit   <= accept && r_s0_valid && (col_cur == r_s0_col);
            r_window    <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_col  <= col_cur;
            r_s0_rgb  <= s_axis_tdata;
            r_s0_emit <= emit;
            r_s0_last <= last;
        end
        r_fwd_data <= ram_wdata;
    end

    gkc_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s0_valid),
        .i_waddr (r_s0_col),
        .i_wdata (ram_wdata),
        .i_raddr (col_cur),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        gray_sum = GPROD_W'(r_s0_rgb[PIX_W-1:0])       * GPROD_W'(GRAY_W_R)
                 + GPROD_W'(r_s0_rgb[2*PIX_W-1:PIX_W]) * GPROD_W'(GRAY_W_G)
                 + GPROD_W'(r_s0_rgb[RGB_W-1:2*PIX_W]) * GPROD_W'(GRAY_W_B);
        gray     = gray_sum[GPROD_W-1:GW_W];
        hist     = r_fwd_hit ? r_fwd_data : ram_rdata;
        for (int l = 0; l < HIST; l++) begin
            fresh[l] = hist[l*PIX_W +: PIX_W];
        end
        fresh[KSIZE-1] = gray;
        for (int l = 0; l < HIST; l++) begin
            ram_wdata[l*PIX_W +: PIX_W] = fresh[l+1];
        end
        n_window = r_window;
        if (r_s0_valid) begin
            for (int l = 0; l < KSIZE; l++) begin
                for (int k = 0; k < KSIZE - 1; k++) begin
                    n_window[l][k] = r_window[l][k+1];
                end
                n_window[l][KSIZE-1] = fresh[l];
            end
        end
    end

    always_comb begin
        o_push         = r_s0_valid && r_s0_emit;
        o_item.row_end = r_s0_last;
        for (int l = 0; l < KSIZE; l++) begin
            for (int k = 0; k < KSIZE; k++) begin
                o_item.taps[l*KSIZE + k] = n_window[l][k];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gkc_queue.sv -----
// Short FIFO of complete windows between the front end and the back end.
// Uses gkc_pkg for the item type and depth.
`default_nettype none

module gkc_queue import gkc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  t_win_item              i_item,
    input  wire logic              i_pop,
    output logic                   o_nonempty,
    output t_win_item              o_head,
    output logic [QLVL_W-1:0]      o_level
);

    t_win_item         r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QLVL_W-1:0] r_count, n_count;

    assign o_nonempty = r_count != '0;
    assign o_head     = r_mem[r_rd_ptr];
    assign o_level    = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QLVL_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QLVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gkc_back.sv -----
// Back end: multiplies a window by the kernel, sums, truncates and clamps,
// and holds the result in the output register. Uses gkc_pkg.
`default_nettype none

module gkc_back import gkc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  t_coeffs               i_coeffs,
    input  wire logic             i_q_nonempty,
    input  t_win_item             i_head,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // value
    output logic                  m_axis_tuser,   // clamped
    output logic                  m_axis_tlast    // row_end
);

    logic                     advance;
    logic                     r_b1_valid;
    logic                     r_b2_valid;
    logic                     r_b1_last;
    logic                     r_b2_last;
    logic signed [PROD_W-1:0] r_prod [TAPS];
    logic signed [PROD_W-1:0] n_prod [TAPS];
    logic signed [RSUM_W-1:0] r_rsum [KSIZE];
    logic signed [RSUM_W-1:0] n_rsum [KSIZE];
    logic signed [SUM_W-1:0]  total;
    logic [PIX_W-1:0]         n_value;
    logic                     n_clamped;

    assign advance = !m_axis_tvalid || m_axis_tready;
    assign o_pop   = advance && i_q_nonempty;

    always_comb begin
        for (int l = 0; l < KSIZE; l++) begin
            for (int k = 0; k < KSIZE; k++) begin
                n_prod[l*KSIZE + k] = PROD_W'($signed({1'b0, i_head.taps[l*KSIZE + k]})
                                    * $signed(i_coeffs[l][k*COEF_W +: COEF_W]));
            end
        end
        for (int l = 0; l < KSIZE; l++) begin
            n_rsum[l] = RSUM_W'(r_prod[l*KSIZE])
                      + RSUM_W'(r_prod[l*KSIZE + 1])
                      + RSUM_W'(r_prod[l*KSIZE + 2]);
        end
        total = SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
        if (total[SUM_W-1]) begin
            n_value   = '0;
            n_clamped = total <= -SUM_W'(256);
        end else if (total[SUM_W-2:FRAC_W+PIX_W] != '0) begin
            n_value   = PIX_MAX;
            n_clamped = 1'b1;
        end else begin
            n_value   = total[FRAC_W+PIX_W-1:FRAC_W];
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid    <= 1'b0;
            r_b2_valid    <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else if (advance) begin
            r_b1_valid    <= i_q_nonempty;
            r_b2_valid    <= r_b1_valid;
            m_axis_tvalid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b1_last <= i_head.row_end;
            r_b2_last <= r_b1_last;
            for (int i = 0; i < TAPS; i++) begin
                r_prod[i] <= n_prod[i];
            end
            for (int l = 0; l < KSIZE; l++) begin
                r_rsum[l] <= n_rsum[l];
            end
            m_axis_tdata <= n_value;
            m_axis_tuser <= n_clamped;
            m_axis_tlast <= r_b2_last;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/grayscale_kernel_convolution.sv -----
// 3x3 convolution of an RGB stream converted to gray.
// Top level: configuration registers, front end, window queue, back end.
// Uses gkc_pkg, gkc_front, gkc_queue, gkc_back.
//
// Usage:
//   s_axis: one RGB pixel per transaction in raster order; tuser marks
//   the first pixel of a frame. m_axis: one filtered gray value per
//   window that lies fully inside the image; tuser flags clamping and
//   tlast marks the last value of an output row.
//   cfg: register writes (index 0 line width, 1..3 kernel rows), always
//   ready; write only while the stream is idle.
//   A result passes the front-end stage, the window queue and the back
//   end's product, row-sum and output registers. Throughput: one pixel
//   per cycle unless stalled, set by the single line-store RAM port pair
//   (one read and one write per pixel). The front end holds a pixel in
//   flight and the queue holds 4 windows; when m_axis stalls, the back
//   end holds its result and s_axis_tready drops once the queue fills.
//   Reset: counters, window and queue are cleared, line width returns to
//   1024 and the kernel to zero; the line store needs no clearing pass.
`default_nettype none

module grayscale_kernel_convolution import gkc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [RGB_W-1:0]     s_axis_tdata,   // red, green, blue
    input  wire logic                 s_axis_tuser,   // frame_start
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [PIX_W-1:0]          m_axis_tdata,   // value
    output logic                      m_axis_tuser,   // clamped
    output logic                      m_axis_tlast,   // row_end
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ROWC_W-1:0]    i_cfg_data
);

    logic [LW_W-1:0]   r_line_width;
    t_coeffs           r_coeffs;
    logic              push;
    t_win_item         push_item;
    logic              pop;
    logic              q_nonempty;
    t_win_item         q_head;
    logic [QLVL_W-1:0] q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_RESET;
            r_coeffs     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data[LW_W-1:0];
                CFG_COEFF_ROW0: r_coeffs[0]  <= i_cfg_data;
                CFG_COEFF_ROW1: r_coeffs[1]  <= i_cfg_data;
                CFG_COEFF_ROW2: r_coeffs[2]  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    gkc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_line_width  (r_line_width),
        .i_q_level     (q_level),
        .o_push        (push),
        .o_item        (push_item)
    );

    gkc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (push_item),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_head     (q_head),
        .o_level    (q_level)
    );

    gkc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coeffs      (r_coeffs),
        .i_q_nonempty  (q_nonempty),
        .i_head        (q_head),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- tb/grayscale_kernel_convolution_checker.sv -----
// Checker for grayscale_kernel_convolution: mirrors the gray conversion, line
// stores and 3x3 kernel to predict every filtered pixel and compares m_axis.
// Depends on gkc_pkg for port widths and register indexes.
`timescale 1ns / 1ps

module grayscale_kernel_convolution_checker import gkc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [RGB_W-1:0]     s_axis_tdata,   // red, green, blue
    input  logic                 s_axis_tuser,   // frame_start
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [PIX_W-1:0]     m_axis_tdata,   // value
    input  logic                 m_axis_tuser,   // clamped
    input  logic                 m_axis_tlast,   // row_end
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROWC_W-1:0]    i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending
);

    localparam int          WIN      = 3;
    localparam int          LINE_MAX = 1024;
    localparam int          ROWS_MAX = 2047;
    localparam int unsigned W_RED    = 19595;
    localparam int unsigned W_GREEN  = 38469;
    localparam int unsigned W_BLUE   = 7471;

    typedef struct packed {
        logic [7:0] value;
        logic       clamped;
        logic       row_end;
    } t_filtered;

    logic [10:0]       line_width;
    logic [ROWC_W-1:0] kernel_rows [WIN];
    logic [7:0]        line_mem [WIN-1][LINE_MAX];
    logic [7:0]        win [WIN][WIN];
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    int                mismatch_count;
    t_filtered         pending_filtered [$];

    function automatic int kernel_coeff(input int l, input int k);
        logic [COEF_W-1:0] raw;
        int                c;
        raw = kernel_rows[l][COEF_W*k +: COEF_W];
        c = $signed(raw);
        return c;
    endfunction

    function automatic bit filter_pixel(input logic [RGB_W-1:0] rgb, input logic first,
                                        output t_filtered res);
        int unsigned w, col, row, gsum;
        logic [7:0]  fresh [WIN];
        int          sum, q, pix, l, k;
        bit          last, emit;
        w = (line_width < WIN) ? WIN : (line_width > LINE_MAX) ? LINE_MAX : line_width;
        if (first) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        col = (col_cnt >= LINE_MAX) ? LINE_MAX - 1 : col_cnt;
        row = row_cnt;
        gsum = rgb[7:0] * W_RED + rgb[15:8] * W_GREEN + rgb[23:16] * W_BLUE;
        fresh[0] = line_mem[0][col];
        fresh[1] = line_mem[1][col];
        fresh[2] = 8'(gsum >> 16);
        line_mem[0][col] = fresh[1];
        line_mem[1][col] = fresh[2];
        for (l = 0; l < WIN; l++) begin
            win[l][0] = win[l][1];
            win[l][1] = win[l][2];
            win[l][2] = fresh[l];
        end
        last = (col + 1 >= w);
        res = '0;
        emit = 1'b0;
        if (col >= 2 && row >= 2) begin
            sum = 0;
            for (l = 0; l < WIN; l++)
                for (k = 0; k < WIN; k++) begin
                    pix = win[l][k];
                    sum += pix * kernel_coeff(l, k);
                end
            q = sum / 256;
            res.clamped = (q < 0) || (q > 255);
            res.value = (q < 0) ? 8'd0 : (q > 255) ? 8'd255 : 8'(q);
            res.row_end = last;
            emit = 1'b1;
        end
        if (last) begin
            col_cnt = 0;
            if (row_cnt < ROWS_MAX)
                row_cnt++;
        end else begin
            col_cnt = col + 1;
        end
        return emit;
    endfunction

    always @(posedge i_clk) begin : watch
        t_filtered want;
        int        i, j;
        if (!i_rst_n) begin
            line_width = 11'd1024;
            for (i = 0; i < WIN; i++) begin
                kernel_rows[i] = '0;
                for (j = 0; j < WIN; j++)
                    win[i][j] = '0;
            end
            for (i = 0; i < WIN - 1; i++)
                for (j = 0; j < LINE_MAX; j++)
                    line_mem[i][j] = '0;
            col_cnt = 0;
            row_cnt = 0;
            mismatch_count = 0;
            pending_filtered.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_WIDTH: line_width = i_cfg_data[10:0];
                    CFG_COEFF_ROW0: kernel_rows[0] = i_cfg_data;
                    CFG_COEFF_ROW1: kernel_rows[1] = i_cfg_data;
                    CFG_COEFF_ROW2: kernel_rows[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (filter_pixel(s_axis_tdata, s_axis_tuser, want))
                    pending_filtered.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_filtered.size() == 0) begin
                    $display("%0t: unexpected result value %0d clamped %0b row_end %0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = pending_filtered.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $display("%0t: value expected %0d actual %0d",
                                 $time, want.value, m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.clamped) begin
                        $display("%0t: clamped expected %0b actual %0b",
                                 $time, want.clamped, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.row_end) begin
                        $display("%0t: row_end expected %0b actual %0b",
                                 $time, want.row_end, m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= pending_filtered.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ----- tb/grayscale_kernel_convolution_test.sv -----
// Top of the grayscale_kernel_convolution testbench: clock, reset, register
// writes, pixel stream and output back-pressure; the checker does the compare.
// Depends on gkc_pkg, grayscale_kernel_convolution and the checker module.
`timescale 1ns / 1ps

module grayscale_kernel_convolution_test;
    import gkc_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_FRAMES = 16;

    localparam logic [RGB_W-1:0] WHITE = 24'hFFFFFF;
    localparam logic [RGB_W-1:0] BLACK = 24'h000000;
    localparam logic [RGB_W-1:0] RED   = 24'h0000FF;
    localparam logic [RGB_W-1:0] GREEN = 24'h00FF00;
    localparam logic [RGB_W-1:0] BLUE  = 24'hFF0000;
    localparam logic [RGB_W-1:0] GRAY1 = 24'h000004;
    localparam logic [RGB_W-1:0] GRAY32 = 24'h00006C;

    localparam logic [RGB_W-1:0] DIRECTED [24] = '{
        WHITE, BLACK, RED,
        GREEN, BLUE, GRAY1,
        GRAY1, BLACK, BLACK,
        BLACK, BLACK, WHITE,
        BLACK, WHITE, BLACK,
        BLACK, BLACK, BLACK,
        BLACK, BLACK, GRAY32,
        WHITE, WHITE, WHITE
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [RGB_W-1:0]     s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ROWC_W-1:0]    i_cfg_data = '0;

    int          mismatch_count;
    int          pending_results;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_req = 1'b0;
    int unsigned hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    grayscale_kernel_convolution uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    grayscale_kernel_convolution_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatch_count),
        .o_pending     (pending_results)
    );

    // hold off for a long stretch on request, else stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_req) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic push_pixel(input logic [RGB_W-1:0] rgb, input logic first);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rgb;
        s_axis_tuser <= first;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ROWC_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_kernel(input logic [10:0] width, input logic [ROWC_W-1:0] r0,
                               input logic [ROWC_W-1:0] r1, input logic [ROWC_W-1:0] r2);
        cfg_write(CFG_LINE_WIDTH, ROWC_W'(width));
        cfg_write(CFG_COEFF_ROW0, r0);
        cfg_write(CFG_COEFF_ROW1, r1);
        cfg_write(CFG_COEFF_ROW2, r2);
    endtask

    // drop valid, wait for every filtered pixel, then let the pipe empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_traffic(input int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 46; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 46; end
            default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
        endcase
    endtask

    function automatic logic [ROWC_W-1:0] random_row();
        logic [ROWC_W-1:0] row;
        int                k;
        for (k = 0; k < KSIZE; k++) begin
            if ($urandom_range(3) == 0)
                row[COEF_W*k +: COEF_W] = COEF_W'($urandom);
            else
                row[COEF_W*k +: COEF_W] = COEF_W'($urandom_range(192) - 96);
        end
        return row;
    endfunction

    function automatic logic [RGB_W-1:0] random_pixel();
        logic [RGB_W-1:0] rgb;
        int               c;
        rgb = RGB_W'($urandom);
        if ($urandom_range(15) == 0)
            for (c = 0; c < 3; c++)
                rgb[PIX_W*c +: PIX_W] = {PIX_W{rgb[PIX_W*c]}};
        return rgb;
    endfunction

    task automatic stream_frame(input int count, input logic new_frame, input bit noisy);
        int  i;
        bit  restart;
        for (i = 0; i < count; i++) begin
            restart = (i == 0 && new_frame) || (noisy && $urandom_range(299) == 0);
            push_pixel(random_pixel(), restart);
        end
    endtask

    initial begin : stimulus
        int          i, ph, lw, eff, count;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // width 3, newest row weighted -1/256, -8, +7.996 from oldest column
        load_kernel(11'd3, '0, '0, 36'h7FF800FFF);
        for (i = 0; i < 24; i++)
            push_pixel(DIRECTED[i], i == 0);

        for (ph = 0; ph < RANDOM_FRAMES; ph++) begin
            case (ph % 8)
                0: lw = 0;
                1: lw = 1;
                2: lw = 2;
                default: lw = $urandom_range(3, 40);
            endcase
            eff = (lw < 3) ? 3 : lw;
            count = eff * ($urandom_range(120 / eff) + 3);
            drain();
            set_traffic(ph % 4);
            load_kernel(11'(lw), random_row(), random_row(), random_row());
            stream_frame(count, 1'b1, ph >= 4);
        end

        // fill the block while the output is held off
        drain();
        set_traffic(0);
        load_kernel(11'd12, random_row(), random_row(), random_row());
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        stream_frame(120, 1'b1, 1'b0);

        // shrink the line in mid-line past the current column
        drain();
        set_traffic(3);
        load_kernel(11'd20, random_row(), random_row(), random_row());
        stream_frame(51, 1'b1, 1'b0);
        drain();
        cfg_write(CFG_LINE_WIDTH, ROWC_W'(8));
        stream_frame(60, 1'b0, 1'b0);

        drain();
        if (mismatch_count == 0 && pending_results == 0)
            $display("grayscale_kernel_convolution test passed");
        else
            $display("grayscale_kernel_convolution test failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("grayscale_kernel_convolution test failed");
        $finish;
    end

endmodule

// ----- grayscale_kernel_convolution.f -----
rtl/core/gkc_pkg.sv
rtl/core/gkc_ram.sv
rtl/core/gkc_front.sv
rtl/core/gkc_queue.sv
rtl/core/gkc_back.sv
rtl/core/grayscale_kernel_convolution.sv
tb/grayscale_kernel_convolution_checker.sv
tb/grayscale_kernel_convolution_test.sv
